>>> hdl/pmsh_pkg.sv
// Package for the PHY mode-switch handshake block.
// Holds the event codes, register map, slot and result types shared by all files.
// No dependencies.
package pmsh_pkg;

    // Mode indices carried on the link are three bits wide.
    localparam int MODE_W = 3;

    // Number of legal modes; a mode index at or above this is ignored.
    localparam int MODE_COUNT = 8;

    // Width of the probation timer register and of the time stamps.
    localparam int PROB_TIME_W = 16;
    localparam int TIME_W      = 32;

    // Stream widths: tdata payloads packed without gaps, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_PROBATION_TIME = 1'b0;
    localparam logic [PROB_TIME_W-1:0] PROBATION_TIME_RESET = 16'd1000;

    // Event codes carried on s_tuser.
    typedef enum logic [2:0] {
        ACT_BEGIN      = 3'd0,
        ACT_REQUEST    = 3'd1,
        ACT_RECEIVED   = 3'd2,
        ACT_SENT       = 3'd3,
        ACT_POLL       = 3'd4,
        ACT_TAKE_APPLY = 3'd5
    } action_t;

    // One-entry slot: a valid bit and the mode it holds.
    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] mode;
    } slot_t;

    // Result beat. Declared from the top bit down so that tx_present lands in bit 0.
    typedef struct packed {
        logic              in_probation;
        logic              busy_res;
        logic [MODE_W-1:0] current_mode;
        logic [MODE_W-1:0] applied_mode;
        logic              applied;
        logic [MODE_W-1:0] tx_mode;
        logic              tx_ack;
        logic              tx_present;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // True when a mode index names a legal mode.
    function automatic logic mode_ok(input logic [MODE_W-1:0] m);
        return 32'(m) < MODE_COUNT;
    endfunction

endpackage

>>> hdl/phy_mode_switch_handshake.sv
// Channel   | Dir | Signals                    | Content
// s_ stream | in  | tvalid tready tdata tuser  | one event beat, tuser = action
// m_ stream | out | tvalid tready tdata        | one result beat per event
// APB       | in  | psel penable pwrite paddr  | probation_time at byte address 0
//
// One event is accepted per cycle while s_tready is high; its result is registered before it shows on m_.
// The whole event decode sits between the state registers and the output register.
// A stalled result is held and one more beat is parked in a skid stage; s_tready
// drops only while that skid stage is full.
// Reset (aresetn, synchronous) clears the modes, slots, probation and the stream,
// and sets probation_time to 1000 ms.
//
// Top level of the PHY mode-switch handshake. Depends on pmsh_pkg, pmsh_core, pmsh_skid.
module phy_mode_switch_handshake (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: mode[2:0], rx_present[3], rx_ack[4], rx_mode[7:5],
    // local_init[8], now_ms[40:9], zero[47:41]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pmsh_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: action[2:0]
    input  logic [pmsh_pkg::S_TUSER_W-1:0]   s_tuser,
    // m_tdata: tx_present[0], tx_ack[1], tx_mode[4:2], applied[5],
    // applied_mode[8:6], current_mode[11:9], busy_res[12], in_probation[13], zero[15:14]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pmsh_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pmsh_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pmsh_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pmsh_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import pmsh_pkg::*;

    logic [PROB_TIME_W-1:0] prob_time_reg;
    logic                   reg_sel;
    logic                   cfg_write;
    logic                   evt_accept;
    result_t                res;
    logic [RESULT_W-1:0]    res_out;

    // Configuration register: one word, decoded by the word address bit.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prob_time_reg <= PROBATION_TIME_RESET;
        end else if (cfg_write && reg_sel == REG_PROBATION_TIME) begin
            prob_time_reg <= pwdata[PROB_TIME_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel == REG_PROBATION_TIME) begin
            prdata = APB_DATA_W'(prob_time_reg);
        end
    end

    // Event decode and handshake state.
    assign evt_accept = s_tvalid && s_tready;

    pmsh_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .evt_accept    (evt_accept),
        .action        (action_t'(s_tuser)),
        .mode          (s_tdata[2:0]),
        .rx_present    (s_tdata[3]),
        .rx_ack        (s_tdata[4]),
        .rx_mode       (s_tdata[7:5]),
        .local_init    (s_tdata[8]),
        .now_ms        (s_tdata[40:9]),
        .probation_time(prob_time_reg),
        .res           (res)
    );

    // Result register and skid stage.
    pmsh_skid #(
        .WIDTH(RESULT_W)
    ) u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (res),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (res_out)
    );

    assign m_tdata = M_TDATA_W'(res_out);

endmodule

>>> hdl/pmsh_core.sv
// Handshake state and event decode for the PHY mode-switch block.
// Updates the mode, slots and probation timer on each accepted beat.
// Depends on pmsh_pkg.
module pmsh_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           evt_accept,
    input  pmsh_pkg::action_t              action,
    input  logic [pmsh_pkg::MODE_W-1:0]    mode,
    input  logic                           rx_present,
    input  logic                           rx_ack,
    input  logic [pmsh_pkg::MODE_W-1:0]    rx_mode,
    input  logic                           local_init,
    input  logic [pmsh_pkg::TIME_W-1:0]    now_ms,
    input  logic [pmsh_pkg::PROB_TIME_W-1:0] probation_time,
    output pmsh_pkg::result_t              res
);
    import pmsh_pkg::*;

    logic [MODE_W-1:0] active_reg,   active_next;
    logic [MODE_W-1:0] fallback_reg, fallback_next;
    slot_t             pending_reg,  pending_next;
    slot_t             armed_reg,    armed_next;
    slot_t             apply_reg,    apply_next;
    slot_t             ack_reg,      ack_next;
    logic              prob_reg,     prob_next;
    logic [TIME_W-1:0] start_reg,    start_next;

    logic              busy_now;
    logic [TIME_W-1:0] elapsed;
    logic              applied;
    logic [MODE_W-1:0] applied_mode;

    localparam slot_t SLOT_EMPTY = '{valid: 1'b0, mode: '0};

    // Event decode: next state from the current state and the incoming beat.
    always_comb begin
        active_next   = active_reg;
        fallback_next = fallback_reg;
        pending_next  = pending_reg;
        armed_next    = armed_reg;
        apply_next    = apply_reg;
        ack_next      = ack_reg;
        prob_next     = prob_reg;
        start_next    = start_reg;
        applied       = 1'b0;
        applied_mode  = '0;
        busy_now      = pending_reg.valid | armed_reg.valid | apply_reg.valid | prob_reg;
        elapsed       = now_ms - start_reg;

        unique case (action)
            ACT_BEGIN: begin
                if (mode_ok(mode)) begin
                    active_next   = mode;
                    fallback_next = mode;
                    pending_next  = SLOT_EMPTY;
                    armed_next    = SLOT_EMPTY;
                    apply_next    = SLOT_EMPTY;
                    ack_next      = SLOT_EMPTY;
                    prob_next     = 1'b0;
                    start_next    = '0;
                end
            end
            ACT_REQUEST: begin
                if (mode_ok(mode) && mode != active_reg && !busy_now) begin
                    pending_next = '{valid: 1'b1, mode: mode};
                end
            end
            ACT_RECEIVED: begin
                // Hearing any frame ends probation.
                prob_next = 1'b0;
                if (rx_present && mode_ok(rx_mode)) begin
                    if (local_init) begin
                        if (rx_ack && pending_reg.valid && rx_mode == pending_reg.mode) begin
                            apply_next   = '{valid: 1'b1, mode: rx_mode};
                            pending_next = SLOT_EMPTY;
                        end
                    end else if (!rx_ack && rx_mode != active_reg && !armed_reg.valid) begin
                        ack_next   = '{valid: 1'b1, mode: rx_mode};
                        armed_next = '{valid: 1'b1, mode: rx_mode};
                    end
                end
            end
            ACT_SENT: begin
                // Our acknowledgement went out: the armed mode becomes an apply.
                if (armed_reg.valid) begin
                    apply_next = '{valid: 1'b1, mode: armed_reg.mode};
                    armed_next = SLOT_EMPTY;
                    ack_next   = SLOT_EMPTY;
                end
            end
            ACT_POLL: begin
                if (prob_reg && elapsed >= TIME_W'(probation_time)) begin
                    prob_next  = 1'b0;
                    apply_next = '{valid: 1'b1, mode: fallback_reg};
                end
            end
            ACT_TAKE_APPLY: begin
                if (apply_reg.valid) begin
                    apply_next = SLOT_EMPTY;
                    if (apply_reg.mode != active_reg) begin
                        fallback_next = active_reg;
                        active_next   = apply_reg.mode;
                    end
                    prob_next    = 1'b1;
                    start_next   = now_ms;
                    applied      = 1'b1;
                    applied_mode = apply_reg.mode;
                end
            end
            default: begin
            end
        endcase
    end

    // Result from the state after this event; an owed ack wins over our request.
    always_comb begin
        res = '0;
        if (ack_next.valid) begin
            res.tx_present = 1'b1;
            res.tx_ack     = 1'b1;
            res.tx_mode    = ack_next.mode;
        end else if (pending_next.valid) begin
            res.tx_present = 1'b1;
            res.tx_ack     = 1'b0;
            res.tx_mode    = pending_next.mode;
        end
        res.applied      = applied;
        res.applied_mode = applied_mode;
        res.current_mode = active_next;
        res.busy_res     = pending_next.valid | armed_next.valid | apply_next.valid | prob_next;
        res.in_probation = prob_next;
    end

    // State registers advance only on an accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= '0;
            fallback_reg <= '0;
            pending_reg  <= SLOT_EMPTY;
            armed_reg    <= SLOT_EMPTY;
            apply_reg    <= SLOT_EMPTY;
            ack_reg      <= SLOT_EMPTY;
            prob_reg     <= 1'b0;
            start_reg    <= '0;
        end else if (evt_accept) begin
            active_reg   <= active_next;
            fallback_reg <= fallback_next;
            pending_reg  <= pending_next;
            armed_reg    <= armed_next;
            apply_reg    <= apply_next;
            ack_reg      <= ack_next;
            prob_reg     <= prob_next;
            start_reg    <= start_next;
        end
    end

endmodule

>>> hdl/pmsh_skid.sv
// Output register with a one-beat skid stage for the result stream.
// Keeps the input side ready while a finished result waits downstream, until the skid stage fills.
// Depends on pmsh_pkg for the default width.
module pmsh_skid #(
    parameter int WIDTH = pmsh_pkg::RESULT_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import pmsh_pkg::*;

    logic             out_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             in_beat;

    assign in_ready  = !skid_valid_reg;
    assign in_beat   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control: output moves when empty or taken; a stalled output spills into the skid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_beat;
            end
        end else if (in_beat) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers follow the same selection.
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_beat) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

>>> hdl/pmsh_checker.sv
// Port-level checks for the PHY mode-switch handshake, bound to the top level.
// Depends on pmsh_pkg and phy_mode_switch_handshake.
module pmsh_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [pmsh_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [pmsh_pkg::S_TUSER_W-1:0]   s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pmsh_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pmsh_pkg::*;

    // A waiting result is never withdrawn.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // With no result waiting, the skid stage must be empty and the input ready.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output is empty");

    // Probation always counts as busy.
    a_prob_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13] |-> m_tdata[12])
        else $error("probation reported without busy");

    // A taken apply starts probation; otherwise the applied mode reads zero.
    a_apply_prob: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5] ? m_tdata[13] : (m_tdata[8:6] == '0)))
        else $error("apply reported without probation or stray applied mode");

    // No control to send means a zero control field.
    a_idle_control: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == '0)
        else $error("control fields set without tx_present");

endmodule

bind phy_mode_switch_handshake pmsh_checker u_pmsh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

>>> test/phy_mode_switch_handshake_tb.sv
// Self-checking testbench for phy_mode_switch_handshake: link events go in on the s_ stream,
// and a status beat is predicted for each of them and checked as it arrives on the m_ stream.
// Depends on pmsh_pkg and the phy_mode_switch_handshake RTL.
`timescale 1ns / 100ps

module phy_mode_switch_handshake_tb;
    import pmsh_pkg::*;

    // Event codes that the block must ignore.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    // Phase count and events per phase. The last phase draws its own probation time.
    localparam int PHASES = 5;
    localparam int PHASE_EVENTS = 380;

    typedef struct {
        logic [2:0]        action;
        logic [MODE_W-1:0] mode;
        logic              rx_present;
        logic              rx_ack;
        logic [MODE_W-1:0] rx_mode;
        logic              local_init;
        logic [TIME_W-1:0] now_ms;
    } link_event_t;

    // Tracks the handshake state and holds the status beats still owed by the block.
    class handshake_tracker;
        logic [MODE_W-1:0]      active;
        logic [MODE_W-1:0]      fallback;
        slot_t                  own_request;
        slot_t                  armed;
        slot_t                  ready_apply;
        slot_t                  ack_due;
        logic                   probation;
        logic [TIME_W-1:0]      prob_start;
        logic [PROB_TIME_W-1:0] prob_time;
        result_t                status_due[$];
        int                     errors;
        int                     events_seen;
        int                     beats_checked;
        int                     applies;
        int                     fall_backs;

        function new();
            prob_time = PROBATION_TIME_RESET;
            restart(3'd0);
        endfunction

        function void restart(logic [MODE_W-1:0] m);
            active      = m;
            fallback    = m;
            own_request = '0;
            armed       = '0;
            ready_apply = '0;
            ack_due     = '0;
            probation   = 1'b0;
            prob_start  = '0;
        endfunction

        function logic switching();
            return own_request.valid || armed.valid || ready_apply.valid || probation;
        endfunction

        // Applies one event and returns the status the block reports after it.
        function result_t next_status(link_event_t ev);
            result_t           st;
            logic [MODE_W-1:0] m;
            st = '0;
            case (ev.action)
                ACT_BEGIN: begin
                    if (32'(ev.mode) < MODE_COUNT) restart(ev.mode);
                end
                ACT_REQUEST: begin
                    if (32'(ev.mode) < MODE_COUNT && ev.mode != active && !switching()) begin
                        own_request.valid = 1'b1;
                        own_request.mode  = ev.mode;
                    end
                end
                ACT_RECEIVED: begin
                    // Hearing any frame ends probation, even one without a usable control.
                    probation = 1'b0;
                    if (ev.rx_present && 32'(ev.rx_mode) < MODE_COUNT) begin
                        if (ev.local_init) begin
                            if (ev.rx_ack && own_request.valid &&
                                ev.rx_mode == own_request.mode) begin
                                ready_apply.valid = 1'b1;
                                ready_apply.mode  = ev.rx_mode;
                                own_request       = '0;
                            end
                        end else if (!ev.rx_ack && ev.rx_mode != active && !armed.valid) begin
                            ack_due.valid = 1'b1;
                            ack_due.mode  = ev.rx_mode;
                            armed.valid   = 1'b1;
                            armed.mode    = ev.rx_mode;
                        end
                    end
                end
                ACT_SENT: begin
                    if (armed.valid) begin
                        ready_apply.valid = 1'b1;
                        ready_apply.mode  = armed.mode;
                        armed             = '0;
                        ack_due           = '0;
                    end
                end
                ACT_POLL: begin
                    if (probation && (ev.now_ms - prob_start) >= 32'(prob_time)) begin
                        probation         = 1'b0;
                        ready_apply.valid = 1'b1;
                        ready_apply.mode  = fallback;
                        fall_backs++;
                    end
                end
                ACT_TAKE_APPLY: begin
                    if (ready_apply.valid) begin
                        m           = ready_apply.mode;
                        ready_apply = '0;
                        if (m != active) begin
                            fallback = active;
                            active   = m;
                        end
                        probation       = 1'b1;
                        prob_start      = ev.now_ms;
                        st.applied      = 1'b1;
                        st.applied_mode = m;
                        applies++;
                    end
                end
                default: ;
            endcase

            // An owed acknowledgement goes out ahead of our own request.
            if (ack_due.valid) begin
                st.tx_present = 1'b1;
                st.tx_ack     = 1'b1;
                st.tx_mode    = ack_due.mode;
            end else if (own_request.valid) begin
                st.tx_present = 1'b1;
                st.tx_mode    = own_request.mode;
            end
            st.current_mode = active;
            st.busy_res     = switching();
            st.in_probation = probation;
            return st;
        endfunction

        function void note_event(link_event_t ev);
            events_seen++;
            status_due.push_back(next_status(ev));
        endfunction

        task complain(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                complain($sformatf("%s is %0d, expected %0d (beat %0d)",
                                   name, got, want, beats_checked));
        endtask

        task check_beat(logic [M_TDATA_W-1:0] beat);
            result_t got;
            result_t want;
            got = result_t'(beat[RESULT_W-1:0]);
            if (status_due.size() == 0) begin
                complain($sformatf("status beat 0x%h with no event waiting", beat));
                return;
            end
            want = status_due.pop_front();
            compare_field("tx_present", got.tx_present, want.tx_present);
            compare_field("tx_ack", got.tx_ack, want.tx_ack);
            compare_field("tx_mode", got.tx_mode, want.tx_mode);
            compare_field("applied", got.applied, want.applied);
            compare_field("applied_mode", got.applied_mode, want.applied_mode);
            compare_field("current_mode", got.current_mode, want.current_mode);
            compare_field("busy_res", got.busy_res, want.busy_res);
            compare_field("in_probation", got.in_probation, want.in_probation);
            compare_field("padding", int'(beat[M_TDATA_W-1:RESULT_W]), 0);
            beats_checked++;
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    handshake_tracker  sb;
    logic [TIME_W-1:0] clock_ms;
    bit                time_walk;
    bit                send_calm;
    bit                recv_calm;
    int                events_sent;

    phy_mode_switch_handshake u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Hard stop in case the block hangs.
    initial begin
        #8_000_000;
        $display("phy_mode_switch_handshake_tb: FAIL");
        $finish;
    end

    // Result side: random stalls with calm stretches in between.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            gap = recv_calm ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end else begin
                @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Check every status beat that is accepted.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
    end

    // Drives one event beat after a random gap and records it once accepted.
    task automatic push_event(link_event_t ev);
        int gap;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.action;
        s_tdata  <= {7'b0, ev.now_ms, ev.local_init, ev.rx_mode, ev.rx_ack,
                     ev.rx_present, ev.mode};
        do @(posedge aclk); while (!s_tready);
        sb.note_event(ev);
        events_sent++;
        // Time moves on between events, now and then with a jump anywhere.
        if (time_walk) begin
            if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
            else clock_ms += $urandom_range(0, 60);
        end
    endtask

    // Event with the given action and random content elsewhere.
    function automatic link_event_t filler(logic [2:0] act);
        link_event_t ev;
        ev.action     = act;
        ev.mode       = 3'($urandom_range(0, 7));
        ev.rx_present = 1'($urandom_range(0, 1));
        ev.rx_ack     = 1'($urandom_range(0, 1));
        ev.rx_mode    = 3'($urandom_range(0, 7));
        ev.local_init = 1'($urandom_range(0, 1));
        ev.now_ms     = clock_ms;
        return ev;
    endfunction

    task automatic send_plain(logic [2:0] act);
        push_event(filler(act));
    endtask

    task automatic send_mode(logic [2:0] act, logic [MODE_W-1:0] m);
        link_event_t ev;
        ev      = filler(act);
        ev.mode = m;
        push_event(ev);
    endtask

    task automatic send_rx(logic present, logic ack, logic [MODE_W-1:0] m, logic init);
        link_event_t ev;
        ev            = filler(ACT_RECEIVED);
        ev.rx_present = present;
        ev.rx_ack     = ack;
        ev.rx_mode    = m;
        ev.local_init = init;
        push_event(ev);
    endtask

    // After an apply: either the peer is heard or probation runs out and we fall back.
    task automatic settle_probation();
        if ($urandom_range(0, 1) == 0) begin
            send_rx($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end else begin
            if (sb.prob_time != 0 && $urandom_range(0, 2) == 0) begin
                clock_ms = sb.prob_start + 32'(sb.prob_time) - 1;
                send_plain(ACT_POLL);
            end
            clock_ms = sb.prob_start + 32'(sb.prob_time) + $urandom_range(0, 3);
            send_plain(ACT_POLL);
            send_plain(ACT_TAKE_APPLY);
        end
    endtask

    function automatic logic [MODE_W-1:0] other_mode();
        logic [MODE_W-1:0] m;
        do m = 3'($urandom_range(0, 7)); while (m == sb.active);
        return m;
    endfunction

    task automatic apb_write(logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PROBATION_TIME, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.prob_time = value[PROB_TIME_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(logic [APB_DATA_W-1:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_PROBATION_TIME, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata != want)
            sb.complain($sformatf("probation_time reads 0x%h, expected 0x%h", prdata, want));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Lowers valid and waits until every owed status beat is back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.status_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic directed_events();
        clock_ms = 32'd0;
        send_mode(ACT_BEGIN, 3'd7);
        send_mode(ACT_BEGIN, 3'd0);
        // Requests for the mode in use and while busy are refused.
        send_mode(ACT_REQUEST, 3'd0);
        send_mode(ACT_REQUEST, 3'd5);
        send_mode(ACT_REQUEST, 3'd3);
        send_rx(1'b0, 1'b1, 3'd5, 1'b1);
        send_rx(1'b1, 1'b1, 3'd4, 1'b1);
        send_rx(1'b1, 1'b1, 3'd5, 1'b1);
        // Probation starts just before the time wraps.
        clock_ms = 32'hFFFF_FF00;
        send_plain(ACT_TAKE_APPLY);
        clock_ms = 32'hFFFF_FF00 + 32'd999;
        send_plain(ACT_POLL);
        clock_ms = 32'hFFFF_FF00 + 32'd1000;
        send_plain(ACT_POLL);
        send_plain(ACT_TAKE_APPLY);
        send_rx(1'b1, 1'b1, 3'd7, 1'b0);
        // Responder side, ending with an apply of the mode already in use.
        send_mode(ACT_BEGIN, 3'd1);
        send_rx(1'b1, 1'b0, 3'd3, 1'b0);
        send_rx(1'b1, 1'b0, 3'd2, 1'b0);
        send_plain(ACT_SENT);
        send_rx(1'b1, 1'b0, 3'd3, 1'b0);
        clock_ms = 32'hFFFF_FFFF;
        send_plain(ACT_TAKE_APPLY);
        send_plain(ACT_SENT);
        send_plain(ACT_TAKE_APPLY);
        send_plain(ACT_SENT);
        send_plain(ACT_TAKE_APPLY);
        send_plain(ACT_SPARE_6);
        send_plain(ACT_SPARE_7);
    endtask

    task automatic random_events(int until_count);
        int                pick;
        logic [MODE_W-1:0] m;
        while (events_sent < until_count) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // We initiate: request, peer acknowledges, we apply.
                m = other_mode();
                send_mode(ACT_REQUEST, m);
                if ($urandom_range(0, 3) == 0) send_plain(ACT_POLL);
                send_rx(1'b1, $urandom_range(0, 9) != 0,
                        ($urandom_range(0, 9) == 0) ? other_mode() : m, 1'b1);
                send_plain(ACT_TAKE_APPLY);
                settle_probation();
            end else if (pick < 60) begin
                // Peer initiates: we acknowledge, send, and apply.
                m = ($urandom_range(0, 9) == 0) ? sb.active : other_mode();
                send_rx(1'b1, $urandom_range(0, 9) == 0, m, 1'b0);
                if ($urandom_range(0, 3) == 0) send_rx(1'b1, 1'b0, other_mode(), 1'b0);
                send_plain(ACT_SENT);
                send_plain(ACT_TAKE_APPLY);
                settle_probation();
            end else if (pick < 66) begin
                send_mode(ACT_BEGIN, 3'($urandom_range(0, 7)));
            end else if (pick < 76) begin
                if (sb.probation) clock_ms = sb.prob_start + 32'(sb.prob_time) - 1 +
                                             $urandom_range(0, 2);
                send_plain(ACT_POLL);
            end else begin
                // Noise: anything at all, the unused codes included.
                clock_ms = ($urandom_range(0, 3) == 0) ? $urandom : clock_ms;
                send_plain(3'($urandom_range(0, 7)));
            end
        end
    endtask

    initial begin
        logic [PROB_TIME_W-1:0] setting;
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        clock_ms  = '0;
        time_walk = 1'b0;
        send_calm = 1'b0;
        recv_calm = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apb_check(32'(PROBATION_TIME_RESET));
        directed_events();
        time_walk = 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: setting = 16'd0;
                    2: setting = 16'hFFFF;
                    3: setting = 16'd1;
                    default: setting = 16'($urandom_range(2, 5000));
                endcase
                apb_write({16'($urandom_range(0, 16'hFFFF)), setting});
                apb_check(32'(setting));
            end
            random_events(events_sent + PHASE_EVENTS);
        end
        drain();
        repeat (20) @(posedge aclk);

        $display("Drove %0d link events over %0d probation settings, %0d status beats checked.",
                 events_sent, PHASES, sb.beats_checked);
        $display("Seen: %0d applies taken, %0d probation fall backs, %0d mismatches.",
                 sb.applies, sb.fall_backs, sb.errors);
        if (sb.errors == 0 && sb.status_due.size() == 0) begin
            $display("phy_mode_switch_handshake_tb: PASS");
        end else begin
            if (sb.status_due.size() != 0)
                $display("%0d status beats never arrived", sb.status_due.size());
            $display("phy_mode_switch_handshake_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/pmsh_pkg.sv
hdl/pmsh_core.sv
hdl/pmsh_skid.sv
hdl/phy_mode_switch_handshake.sv
hdl/pmsh_checker.sv
test/phy_mode_switch_handshake_tb.sv
